FILE: hdl/ppct_pkg.sv
// Shared types and constants of the pointer packet cursor tracker.
package ppct_pkg;

    localparam int CFG_ADDR_W   = 3;
    localparam int CFG_DATA_W   = 32;
    localparam int SIZE_FIELD_W = 13;
    localparam int CFG_IDX_BIT  = 2;

    localparam int RESET_SCREEN_WIDTH  = 320;
    localparam int RESET_SCREEN_HEIGHT = 200;

    localparam int TOUCH_W = 16;

    typedef enum logic {
        REG_SCREEN_WIDTH  = 1'b0,
        REG_SCREEN_HEIGHT = 1'b1
    } reg_index_t;

    typedef enum logic {
        FUNC_PS2   = 1'b0,
        FUNC_TOUCH = 1'b1
    } func_t;

    typedef enum logic [2:0] {
        EV_IGNORED  = 3'd0,
        EV_STORED   = 3'd1,
        EV_APPLIED  = 3'd2,
        EV_OVERFLOW = 3'd3,
        EV_REPORT   = 3'd4,
        EV_REJECTED = 3'd5
    } event_code_t;

    typedef enum logic [2:0] {
        POS_HEADER = 3'b001,
        POS_DX     = 3'b010,
        POS_DY     = 3'b100
    } byte_pos_t;

    localparam logic [7:0] HDR_SYNC_MASK = 8'h08;
    localparam logic [7:0] HDR_OVF_MASK  = 8'hC0;
    localparam int HDR_LEFT_BIT    = 0;
    localparam int HDR_RIGHT_BIT   = 1;
    localparam int HDR_MIDDLE_BIT  = 2;
    localparam int HDR_XSIGN_BIT   = 4;
    localparam int HDR_YSIGN_BIT   = 5;
    localparam int STATUS_LEFT_BIT = 0;

    localparam logic [15:0] REPORT_MAX_LEN = 16'd32;

    typedef struct packed {
        logic left;
        logic right;
        logic middle;
    } buttons_t;

    typedef struct packed {
        event_code_t code;
        byte_pos_t   pos_next;
        logic        header_we;
        logic        dx_we;
        logic        buttons_we;
        buttons_t    buttons;
        logic        move;
    } ps2_ctl_t;

    typedef struct packed {
        event_code_t code;
        logic        left_we;
        logic        left;
        logic        move;
    } touch_ctl_t;

endpackage

FILE: hdl/ppct_regs.sv
// Screen size registers behind the APB-style configuration port.
module ppct_regs #(
    parameter int COORD_BITS = 12
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ppct_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [ppct_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [ppct_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready,
    output logic [COORD_BITS:0]                 width,
    output logic [COORD_BITS:0]                 height,
    output logic [COORD_BITS:0]                 width_next,
    output logic [COORD_BITS:0]                 height_next,
    output logic                                cfg_we
);
    import ppct_pkg::*;

    localparam int SIZE_W   = COORD_BITS + 1;
    localparam int LIM_W    = (SIZE_W > SIZE_FIELD_W) ? SIZE_W : SIZE_FIELD_W;
    localparam int SIZE_TOP = 1 << COORD_BITS;
    localparam int W_RESET  = (RESET_SCREEN_WIDTH > SIZE_TOP) ? SIZE_TOP : RESET_SCREEN_WIDTH;
    localparam int H_RESET  = (RESET_SCREEN_HEIGHT > SIZE_TOP) ? SIZE_TOP : RESET_SCREEN_HEIGHT;

    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;
    logic [LIM_W-1:0]  field;
    logic [LIM_W-1:0]  limited;
    reg_index_t        idx;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;
    assign idx    = reg_index_t'(paddr[CFG_IDX_BIT]);
    assign field  = LIM_W'(pwdata[SIZE_FIELD_W-1:0]);

    // Zero reads as one, anything past the coordinate range as the full range
    always_comb
    begin
        if (field == '0)
        begin
            limited = LIM_W'(1);
        end
        else if (field > LIM_W'(SIZE_TOP))
        begin
            limited = LIM_W'(SIZE_TOP);
        end
        else
        begin
            limited = field;
        end
    end

    assign width_next  = (cfg_we && idx == REG_SCREEN_WIDTH)  ? limited[SIZE_W-1:0] : width_reg;
    assign height_next = (cfg_we && idx == REG_SCREEN_HEIGHT) ? limited[SIZE_W-1:0] : height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SIZE_W'(W_RESET);
            height_reg <= SIZE_W'(H_RESET);
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    assign width  = width_reg;
    assign height = height_reg;
    assign prdata = (idx == REG_SCREEN_WIDTH) ? CFG_DATA_W'(width_reg) : CFG_DATA_W'(height_reg);

endmodule

FILE: hdl/ppct_axis_step.sv
// Relative move of one cursor axis, clamped to the screen.
module ppct_axis_step #(
    parameter int COORD_BITS = 12
) (
    input  logic [COORD_BITS-1:0] pos,
    input  logic signed [8:0]     delta,
    input  logic                  subtract,
    input  logic [COORD_BITS:0]   size,
    output logic [COORD_BITS-1:0] pos_next
);
    localparam int SUM_W = COORD_BITS + 2;

    logic signed [SUM_W-1:0] pos_ext;
    logic signed [SUM_W-1:0] delta_ext;
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] size_ext;
    logic [COORD_BITS:0]     last;

    assign pos_ext   = signed'({2'b00, pos});
    assign delta_ext = SUM_W'(delta);
    assign size_ext  = signed'({1'b0, size});
    assign last      = size - 1'b1;
    assign sum       = subtract ? (pos_ext - delta_ext) : (pos_ext + delta_ext);

    always_comb
    begin
        if (sum < 0)
        begin
            pos_next = '0;
        end
        else if (sum >= size_ext)
        begin
            pos_next = last[COORD_BITS-1:0];
        end
        else
        begin
            pos_next = sum[COORD_BITS-1:0];
        end
    end

endmodule

FILE: hdl/ppct_ps2.sv
// PS/2 mouse packet assembly and relative cursor update.
module ppct_ps2 #(
    parameter int COORD_BITS = 12
) (
    input  logic                       data_present,
    input  logic                       from_aux_port,
    input  logic [7:0]                 data_byte,
    input  ppct_pkg::byte_pos_t        pos,
    input  logic [7:0]                 header_byte,
    input  logic [7:0]                 dx_byte,
    input  logic [COORD_BITS-1:0]      col,
    input  logic [COORD_BITS-1:0]      row,
    input  logic [COORD_BITS:0]        width,
    input  logic [COORD_BITS:0]        height,
    output ppct_pkg::ps2_ctl_t         ctl,
    output logic [COORD_BITS-1:0]      col_next,
    output logic [COORD_BITS-1:0]      row_next
);
    import ppct_pkg::*;

    logic signed [8:0] dx;
    logic signed [8:0] dy;

    assign dx = signed'({header_byte[HDR_XSIGN_BIT], dx_byte});
    assign dy = signed'({header_byte[HDR_YSIGN_BIT], data_byte});

    always_comb
    begin
        ctl.code           = EV_IGNORED;
        ctl.pos_next       = pos;
        ctl.header_we      = 1'b0;
        ctl.dx_we          = 1'b0;
        ctl.buttons_we     = 1'b0;
        ctl.buttons.left   = header_byte[HDR_LEFT_BIT];
        ctl.buttons.right  = header_byte[HDR_RIGHT_BIT];
        ctl.buttons.middle = header_byte[HDR_MIDDLE_BIT];
        ctl.move           = 1'b0;
        if (data_present && from_aux_port)
        begin
            case (pos)
                POS_HEADER:
                begin
                    // drop a first byte without the sync bit
                    if ((data_byte & HDR_SYNC_MASK) != '0)
                    begin
                        ctl.header_we = 1'b1;
                        ctl.pos_next  = POS_DX;
                        ctl.code      = EV_STORED;
                    end
                end
                POS_DX:
                begin
                    ctl.dx_we    = 1'b1;
                    ctl.pos_next = POS_DY;
                    ctl.code     = EV_STORED;
                end
                POS_DY:
                begin
                    ctl.pos_next   = POS_HEADER;
                    ctl.buttons_we = 1'b1;
                    if ((header_byte & HDR_OVF_MASK) != '0)
                    begin
                        ctl.code = EV_OVERFLOW;
                    end
                    else
                    begin
                        ctl.code = EV_APPLIED;
                        ctl.move = 1'b1;
                    end
                end
                default:
                begin
                    ctl.pos_next = POS_HEADER;
                end
            endcase
        end
    end

    ppct_axis_step #(.COORD_BITS(COORD_BITS)) u_step_x (
        .pos      (col),
        .delta    (dx),
        .subtract (1'b0),
        .size     (width),
        .pos_next (col_next)
    );

    ppct_axis_step #(.COORD_BITS(COORD_BITS)) u_step_y (
        .pos      (row),
        .delta    (dy),
        .subtract (1'b1),
        .size     (height),
        .pos_next (row_next)
    );

endmodule

FILE: hdl/ppct_touch.sv
// Trackpad report check and absolute coordinate mapping.
module ppct_touch #(
    parameter int COORD_BITS        = 12,
    parameter int TOUCH_SCALE_SHIFT = 12
) (
    input  logic [15:0]                report_length,
    input  logic [7:0]                 report_status,
    input  logic [15:0]                touch_x,
    input  logic [15:0]                touch_y,
    input  logic [COORD_BITS:0]        width,
    input  logic [COORD_BITS:0]        height,
    output ppct_pkg::touch_ctl_t       ctl,
    output logic [COORD_BITS-1:0]      col_map,
    output logic [COORD_BITS-1:0]      row_map
);
    import ppct_pkg::*;

    localparam int PROD_W = TOUCH_W + COORD_BITS + 1;

    logic [PROD_W-1:0]   prod_x;
    logic [PROD_W-1:0]   prod_y;
    logic [PROD_W-1:0]   scaled_x;
    logic [PROD_W-1:0]   scaled_y;
    logic [COORD_BITS:0] last_x;
    logic [COORD_BITS:0] last_y;

    assign prod_x   = PROD_W'(touch_x) * PROD_W'(width);
    assign prod_y   = PROD_W'(touch_y) * PROD_W'(height);
    assign scaled_x = prod_x >> TOUCH_SCALE_SHIFT;
    assign scaled_y = prod_y >> TOUCH_SCALE_SHIFT;
    assign last_x   = width - 1'b1;
    assign last_y   = height - 1'b1;

    assign col_map = (scaled_x >= PROD_W'(width))  ? last_x[COORD_BITS-1:0]
                                                   : scaled_x[COORD_BITS-1:0];
    assign row_map = (scaled_y >= PROD_W'(height)) ? last_y[COORD_BITS-1:0]
                                                   : scaled_y[COORD_BITS-1:0];

    always_comb
    begin
        ctl.left = report_status[STATUS_LEFT_BIT];
        if (report_length == '0 || report_length > REPORT_MAX_LEN)
        begin
            ctl.code    = EV_REJECTED;
            ctl.left_we = 1'b0;
            ctl.move    = 1'b0;
        end
        else
        begin
            ctl.code    = EV_REPORT;
            ctl.left_we = 1'b1;
            ctl.move    = (touch_x != '0) && (touch_y != '0);
        end
    end

endmodule

FILE: hdl/pointer_packet_cursor_tracker_core.sv
// Top level of the pointer packet cursor tracker.
//
// Keeps a screen cursor and three button flags from pointing-device input and
// returns one result transaction per input transaction. func = 0 carries a
// PS/2 controller byte: it counts only when data_present and from_aux_port are
// both set, and three bytes form a packet (the first must have bit 3 set, or it
// is dropped). A full packet updates the buttons and, without an overflow bit,
// adds dx and subtracts dy, clamped to the screen. func = 1 carries a trackpad
// report: length 0 or above 32 is rejected; otherwise the left button follows
// status bit 0 and, when both raw coordinates are non-zero, the cursor is set
// to raw * size >> TOUCH_SCALE_SHIFT, clamped to size - 1. Throughput is one
// transaction per clock cycle while out_ready does not stall the result. An
// accepted transaction passes one input register and one result register,
// with decode, one 16 x (COORD_BITS+1) multiply per axis and a clamp between
// them. The input register lets a new transaction in while the last result
// waits in the result register. Screen width and height sit at byte addresses
// 0 and 4 of the APB port (0 reads as 1, above 2^COORD_BITS as 2^COORD_BITS);
// writing either recentres the cursor. Write them only while the block is idle.
module pointer_packet_cursor_tracker_core #(
    parameter int COORD_BITS        = 12,
    parameter int TOUCH_SCALE_SHIFT = 12
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ppct_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [ppct_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [ppct_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                             pready,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             func,
    input  logic                             data_present,
    input  logic                             from_aux_port,
    input  logic [7:0]                       data_byte,
    input  logic [15:0]                      report_length,
    input  logic [7:0]                       report_status,
    input  logic [15:0]                      touch_x,
    input  logic [15:0]                      touch_y,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [COORD_BITS-1:0]            cursor_x,
    output logic [COORD_BITS-1:0]            cursor_y,
    output logic                             left_button,
    output logic                             right_button,
    output logic                             middle_button,
    output logic [2:0]                       event_code
);
    import ppct_pkg::*;

    localparam int SIZE_W   = COORD_BITS + 1;
    localparam int SIZE_TOP = 1 << COORD_BITS;
    localparam int W_RESET  = (RESET_SCREEN_WIDTH > SIZE_TOP) ? SIZE_TOP : RESET_SCREEN_WIDTH;
    localparam int H_RESET  = (RESET_SCREEN_HEIGHT > SIZE_TOP) ? SIZE_TOP : RESET_SCREEN_HEIGHT;

    // Configuration
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
    logic [SIZE_W-1:0] width_next;
    logic [SIZE_W-1:0] height_next;
    logic [SIZE_W-1:0] half_width;
    logic [SIZE_W-1:0] half_height;
    logic              cfg_we;

    // Input register
    logic        item_valid_reg;
    func_t       func_reg;
    logic        data_present_reg;
    logic        from_aux_port_reg;
    logic [7:0]  data_byte_reg;
    logic [15:0] report_length_reg;
    logic [7:0]  report_status_reg;
    logic [15:0] touch_x_reg;
    logic [15:0] touch_y_reg;

    // Tracker state
    logic [COORD_BITS-1:0] col_reg;
    logic [COORD_BITS-1:0] col_next;
    logic [COORD_BITS-1:0] row_reg;
    logic [COORD_BITS-1:0] row_next;
    byte_pos_t             pos_reg;
    byte_pos_t             pos_next;
    logic [7:0]            header_reg;
    logic [7:0]            header_next;
    logic [7:0]            dx_reg;
    logic [7:0]            dx_next;
    buttons_t              buttons_reg;
    buttons_t              buttons_next;
    event_code_t           code_next;

    // Result register
    logic                  out_valid_reg;
    logic [COORD_BITS-1:0] cursor_x_reg;
    logic [COORD_BITS-1:0] cursor_y_reg;
    buttons_t              buttons_out_reg;
    event_code_t           event_code_reg;

    // Step logic
    ps2_ctl_t              ps2_ctl;
    touch_ctl_t            touch_ctl;
    logic [COORD_BITS-1:0] ps2_col;
    logic [COORD_BITS-1:0] ps2_row;
    logic [COORD_BITS-1:0] touch_col;
    logic [COORD_BITS-1:0] touch_row;

    logic in_accept;
    logic out_free;
    logic step;

    ppct_regs #(.COORD_BITS(COORD_BITS)) u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .width       (width),
        .height      (height),
        .width_next  (width_next),
        .height_next (height_next),
        .cfg_we      (cfg_we)
    );

    // Handshake: the result register frees up when empty or being taken;
    // the held transaction then steps into it.
    assign out_free  = !out_valid_reg || out_ready;
    assign step      = item_valid_reg && out_free;
    assign in_ready  = !item_valid_reg || out_free;
    assign in_accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            item_valid_reg <= 1'b1;
        end
        else if (step)
        begin
            item_valid_reg <= 1'b0;
        end
    end

    // Hold the transaction payload until it steps
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            func_reg          <= func_t'(func);
            data_present_reg  <= data_present;
            from_aux_port_reg <= from_aux_port;
            data_byte_reg     <= data_byte;
            report_length_reg <= report_length;
            report_status_reg <= report_status;
            touch_x_reg       <= touch_x;
            touch_y_reg       <= touch_y;
        end
    end

    ppct_ps2 #(.COORD_BITS(COORD_BITS)) u_ps2 (
        .data_present  (data_present_reg),
        .from_aux_port (from_aux_port_reg),
        .data_byte     (data_byte_reg),
        .pos           (pos_reg),
        .header_byte   (header_reg),
        .dx_byte       (dx_reg),
        .col           (col_reg),
        .row           (row_reg),
        .width         (width),
        .height        (height),
        .ctl           (ps2_ctl),
        .col_next      (ps2_col),
        .row_next      (ps2_row)
    );

    ppct_touch #(
        .COORD_BITS        (COORD_BITS),
        .TOUCH_SCALE_SHIFT (TOUCH_SCALE_SHIFT)
    ) u_touch (
        .report_length (report_length_reg),
        .report_status (report_status_reg),
        .touch_x       (touch_x_reg),
        .touch_y       (touch_y_reg),
        .width         (width),
        .height        (height),
        .ctl           (touch_ctl),
        .col_map       (touch_col),
        .row_map       (touch_row)
    );

    // Merge the two paths; a trackpad report leaves a half-built packet alone
    always_comb
    begin
        col_next     = col_reg;
        row_next     = row_reg;
        pos_next     = pos_reg;
        header_next  = header_reg;
        dx_next      = dx_reg;
        buttons_next = buttons_reg;
        if (func_reg == FUNC_TOUCH)
        begin
            code_next = touch_ctl.code;
            if (touch_ctl.left_we)
            begin
                buttons_next.left = touch_ctl.left;
            end
            if (touch_ctl.move)
            begin
                col_next = touch_col;
                row_next = touch_row;
            end
        end
        else
        begin
            code_next = ps2_ctl.code;
            pos_next  = ps2_ctl.pos_next;
            if (ps2_ctl.header_we)
            begin
                header_next = data_byte_reg;
            end
            if (ps2_ctl.dx_we)
            begin
                dx_next = data_byte_reg;
            end
            if (ps2_ctl.buttons_we)
            begin
                buttons_next = ps2_ctl.buttons;
            end
            if (ps2_ctl.move)
            begin
                col_next = ps2_col;
                row_next = ps2_row;
            end
        end
    end

    assign half_width  = width_next >> 1;
    assign half_height = height_next >> 1;

    // Recentre on a size write; otherwise advance the state on each step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= COORD_BITS'(W_RESET / 2);
            row_reg     <= COORD_BITS'(H_RESET / 2);
            pos_reg     <= POS_HEADER;
            buttons_reg <= '0;
        end
        else if (cfg_we)
        begin
            col_reg <= half_width[COORD_BITS-1:0];
            row_reg <= half_height[COORD_BITS-1:0];
        end
        else if (step)
        begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            pos_reg     <= pos_next;
            buttons_reg <= buttons_next;
        end
    end

    // Packet bytes are always written before they are read
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            header_reg <= header_next;
            dx_reg     <= dx_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            cursor_x_reg    <= col_next;
            cursor_y_reg    <= row_next;
            buttons_out_reg <= buttons_next;
            event_code_reg  <= code_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign cursor_x      = cursor_x_reg;
    assign cursor_y      = cursor_y_reg;
    assign left_button   = buttons_out_reg.left;
    assign right_button  = buttons_out_reg.right;
    assign middle_button = buttons_out_reg.middle;
    assign event_code    = event_code_reg;

endmodule

FILE: hdl/ppct_checker.sv
// Port-level checks for the pointer packet cursor tracker, bound to the top level.
module ppct_checker #(
    parameter int COORD_BITS = 12
) (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [COORD_BITS-1:0]            cursor_x,
    input logic [COORD_BITS-1:0]            cursor_y,
    input logic                             left_button,
    input logic                             right_button,
    input logic                             middle_button,
    input logic [2:0]                       event_code
);
    import ppct_pkg::*;

    // Input back-pressure only while a result is stalled
    a_ready_low_means_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("in_ready low without a stalled result");

    // A stalled result holds
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(cursor_x) && $stable(cursor_y)
            && $stable(event_code) && $stable(left_button) && $stable(right_button)
            && $stable(middle_button)))
        else $error("stalled result changed");

    // Event codes stay within the defined set
    a_event_code_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (event_code <= EV_REJECTED))
        else $error("undefined event code");

    // A transaction accepted while no result is shown has a result waiting once it
    // has passed the input register and the result register
    a_step_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !out_valid) |=> ##1 out_valid)
        else $error("accepted transaction did not reach the result register");

endmodule

bind pointer_packet_cursor_tracker_core ppct_checker #(.COORD_BITS(COORD_BITS))
    u_ppct_checker (.*);
